// File: rtl/core/sirt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types, register codes, characters and reciprocal table of the
// signed integer to radix text unit.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int DEF_MAX_BASE_DIGITS = 16;
  localparam int DEF_VALUE_WIDTH     = 32;

  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int WORD_W   = 64;
  localparam int DIGIT_W  = 4;
  localparam int ALPHA_N  = 16;
  localparam int ALPHA_W  = ALPHA_N * CHAR_W;
  localparam int RECIP_N  = 32;
  localparam int RECIP_W  = 64;

  localparam logic [COUNT_W-1:0] RST_DIGIT_COUNT = 5'd10;
  localparam logic [WORD_W-1:0]  RST_DIGITS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [WORD_W-1:0]  RST_DIGITS_HIGH = 64'h0000_0000_0000_3938;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    REG_DIGIT_COUNT = 2'd0,
    REG_DIGITS_LOW  = 2'd1,
    REG_DIGITS_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_FIX,
    S_SIGN,
    S_DIGITS
  } state_t;

  localparam logic [RECIP_W:0] TWO_POW_64 = {1'b1, {RECIP_W{1'b0}}};

  // floor(2^64 / base); entries for bases that can never be valid are zero
  localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_N] = '{
    64'd0, 64'd0,
    RECIP_W'(TWO_POW_64 / 65'd2),  RECIP_W'(TWO_POW_64 / 65'd3),
    RECIP_W'(TWO_POW_64 / 65'd4),  RECIP_W'(TWO_POW_64 / 65'd5),
    RECIP_W'(TWO_POW_64 / 65'd6),  RECIP_W'(TWO_POW_64 / 65'd7),
    RECIP_W'(TWO_POW_64 / 65'd8),  RECIP_W'(TWO_POW_64 / 65'd9),
    RECIP_W'(TWO_POW_64 / 65'd10), RECIP_W'(TWO_POW_64 / 65'd11),
    RECIP_W'(TWO_POW_64 / 65'd12), RECIP_W'(TWO_POW_64 / 65'd13),
    RECIP_W'(TWO_POW_64 / 65'd14), RECIP_W'(TWO_POW_64 / 65'd15),
    RECIP_W'(TWO_POW_64 / 65'd16),
    64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
    64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0
  };

endpackage

// File: rtl/core/sirt_alpha_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_alpha_check
// Registered validity flag of the configured digit alphabet.
// ----------------------------------------------------------------------------
module sirt_alpha_check #(
  parameter int MAX_BASE_DIGITS = sirt_pkg::DEF_MAX_BASE_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sirt_pkg::COUNT_W-1:0]  digit_count,
  input  logic [sirt_pkg::ALPHA_W-1:0]  alphabet,
  output logic                          alpha_ok
);
  import sirt_pkg::*;

  logic ok_r;
  logic ok_nxt;

  always_comb begin
    logic [CHAR_W-1:0] ci;
    ok_nxt = (digit_count >= COUNT_W'(2)) &&
             (digit_count <= COUNT_W'(MAX_BASE_DIGITS));
    for (int i = 0; i < MAX_BASE_DIGITS; i++) begin
      ci = alphabet[CHAR_W*i +: CHAR_W];
      if (COUNT_W'(i) < digit_count) begin
        if (ci == CHAR_NUL || ci == CHAR_SPACE || ci == CHAR_PLUS || ci == CHAR_MINUS) begin
          ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE_DIGITS; j++) begin
          if (COUNT_W'(j) < digit_count && alphabet[CHAR_W*j +: CHAR_W] == ci) begin
            ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  // Recomputed every cycle; config must only move while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= ok_nxt;
    end
  end

  assign alpha_ok = ok_r;

endmodule

// File: rtl/core/sirt_div_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sirt_div_unit
// Divide by the small base: reciprocal multiply, registered, then one
// compare-and-subtract correction.
// ----------------------------------------------------------------------------
module sirt_div_unit #(
  parameter int VALUE_WIDTH = sirt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic [VALUE_WIDTH-1:0]        mag,
  input  logic [sirt_pkg::COUNT_W-1:0]  base,
  output logic [VALUE_WIDTH-1:0]        quo,
  output logic [sirt_pkg::DIGIT_W-1:0]  rem
);
  import sirt_pkg::*;

  localparam int W = VALUE_WIDTH;

  logic [W-1:0]   recip;
  logic [2*W-1:0] prod_r;
  logic [W-1:0]   q_est;
  logic [W-1:0]   r_est;
  logic [W-1:0]   base_w;
  logic           fix;

  // floor(2^W / base), the top W bits of the 64-bit table entry
  assign recip = W'(RECIP_TABLE[base] >> (RECIP_W - W));

  // Mag must be held stable for the cycle after the product is taken.
  always_ff @(posedge clk) begin
    prod_r <= (2*W)'(mag) * (2*W)'(recip);
  end

  // Estimate is low by at most one.
  assign q_est  = prod_r[2*W-1:W];
  assign base_w = W'(base);
  assign r_est  = mag - W'(q_est * base_w);
  assign fix    = (r_est >= base_w);
  assign quo    = fix ? q_est + W'(1) : q_est;
  assign rem    = fix ? DIGIT_W'(r_est - base_w) : DIGIT_W'(r_est);

endmodule

// File: rtl/core/signed_integer_to_radix_text_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_unit
// Writes a signed integer as text in a configurable base, one char per item.
// ----------------------------------------------------------------------------
// Each accepted value is written out as text, one character per output item:
// a '-' for a negative value, then the digits of its magnitude in base
// digit_count, most significant first; the final character carries
// last_char. The most negative value is written exactly. If the alphabet is
// invalid (count outside 2..MAX_BASE_DIGITS, a zero byte, space, '+' or '-'
// among the used digits, or a repeated digit) the value produces nothing.
// One value at a time: in_ready is high only while idle. A value passes
// S_IDLE (accept), S_CHECK, then S_FIX for the first digit and S_MUL then
// S_FIX for each further digit in the shared divider (reciprocal multiply,
// then correction), then goes out one character per cycle on the output
// register while the sink keeps up. A value under an invalid alphabet
// returns to S_IDLE from S_CHECK.
// Config registers: 0 digit_count, 1 digits_low, 2 digits_high; write them
// only while the unit is idle.
module signed_integer_to_radix_text_unit #(
  parameter int MAX_BASE_DIGITS = sirt_pkg::DEF_MAX_BASE_DIGITS,
  parameter int VALUE_WIDTH     = sirt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [sirt_pkg::WORD_W-1:0]         cfg_wdata,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sirt_pkg::CHAR_W-1:0]         out_char_out,
  output logic                                out_last_char
);
  import sirt_pkg::*;

  localparam int W    = VALUE_WIDTH;
  localparam int IDXW = $clog2(W);

  // config registers
  logic [COUNT_W-1:0] digit_count_r;
  logic [WORD_W-1:0]  digits_low_r;
  logic [WORD_W-1:0]  digits_high_r;
  logic [ALPHA_W-1:0] alphabet;
  logic               alpha_ok;

  // sequencer and datapath
  state_t             state_r, state_nxt;
  logic [W-1:0]       mag_r;
  logic               neg_r;
  logic [IDXW-1:0]    cnt_r;
  logic [IDXW-1:0]    ptr_r;
  logic [DIGIT_W-1:0] dbuf_r [W];
  logic [W-1:0]       div_quo;
  logic [DIGIT_W-1:0] div_rem;
  logic [W-1:0]       in_mag;
  logic               in_fire;
  logic               conv_done;
  logic               out_load;
  logic               emit;
  logic               div_step;

  // output register
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= RST_DIGIT_COUNT;
      digits_low_r  <= RST_DIGITS_LOW;
      digits_high_r <= RST_DIGITS_HIGH;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DIGIT_COUNT: digit_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_DIGITS_LOW:  digits_low_r  <= cfg_wdata;
        REG_DIGITS_HIGH: digits_high_r <= cfg_wdata;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign alphabet = {digits_high_r, digits_low_r};

  sirt_alpha_check #(
    .MAX_BASE_DIGITS (MAX_BASE_DIGITS)
  ) u_alpha_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .digit_count (digit_count_r),
    .alphabet    (alphabet),
    .alpha_ok    (alpha_ok)
  );

  // ----------------------------------------------------------- shared divider
  sirt_div_unit #(
    .VALUE_WIDTH (W)
  ) u_div_unit (
    .clk  (clk),
    .mag  (mag_r),
    .base (digit_count_r),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // ------------------------------------------------------------- sequencer
  assign in_fire   = in_valid && in_ready;
  assign out_load  = !out_valid_r || out_ready;
  assign conv_done = (div_quo == '0) || (cnt_r == IDXW'(W - 1));

  // Two's complement magnitude; the most negative value comes out as 2^(W-1).
  assign in_mag = in_value[W-1] ? (~$unsigned(in_value)) + W'(1) : $unsigned(in_value);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_CHECK;
      // The product for the first digit is taken during the check cycle.
      S_CHECK:  state_nxt = alpha_ok ? S_FIX : S_IDLE;
      S_MUL:    state_nxt = S_FIX;
      S_FIX: begin
        if (!conv_done) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_DIGITS;
        end
      end
      S_SIGN:   if (out_load) state_nxt = S_DIGITS;
      S_DIGITS: if (out_load && ptr_r == '0) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    div_step = (state_r == S_FIX);
    emit     = (state_r == S_SIGN || state_r == S_DIGITS) && out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the magnitude while the divider works; advance it by one digit.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_r <= in_mag;
      neg_r <= in_value[W-1];
      cnt_r <= '0;
    end else if (div_step) begin
      mag_r         <= div_quo;
      dbuf_r[cnt_r] <= div_rem;
      cnt_r         <= cnt_r + IDXW'(1);
    end
  end

  // Read pointer starts at the most significant digit and walks down.
  always_ff @(posedge clk) begin
    if (div_step && conv_done) begin
      ptr_r <= cnt_r;
    end else if (emit && state_r == S_DIGITS && ptr_r != '0) begin
      ptr_r <= ptr_r - IDXW'(1);
    end
  end

  // -------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state_r == S_SIGN) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= alphabet[CHAR_W*dbuf_r[ptr_r] +: CHAR_W];
        out_last_r <= (ptr_r == '0);
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

  // ------------------------------------------------------------ assertions
  // The corrected remainder is always a legal digit of the base.
  a_rem_in_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |-> COUNT_W'(div_rem) < digit_count_r)
    else $error("divider remainder not below base");

  // Every step strictly shrinks a nonzero magnitude.
  a_div_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX && mag_r != '0) |-> div_quo < mag_r)
    else $error("divider quotient does not shrink magnitude");

  // No zero byte leaves the unit: only validated alphabet characters or the sign are sent.
  a_no_nul_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_char_r != CHAR_NUL)
    else $error("zero byte on output");

  // A sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == CHAR_MINUS && state_r == S_DIGITS) |-> !out_last_r)
    else $error("sign flagged as last character");

endmodule
